/* sv/awp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// awp_pkg
// Shared types, codes and default sizes of the adaptive weighted picker.
// ----------------------------------------------------------------------------
package awp_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int WEIGHT_MAX_DEF  = 100;

  localparam int FUNC_W   = 2;
  localparam int LWGT_W   = 7;
  localparam int COUNT_W  = 16;
  localparam int DRAW_W   = 17;
  localparam int IDX_W    = 10;
  localparam int OWGT_W   = 7;
  localparam int TOTAL_W  = 17;
  localparam int STATUS_W = 2;
  localparam int STEP_W   = 7;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // item functions
  localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PICK    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CORRECT = 2'd2;
  localparam logic [FUNC_W-1:0] FN_WRONG   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // test modes
  localparam logic [MODE_W-1:0] TM_TRANS = 2'd0;
  localparam logic [MODE_W-1:0] TM_WORD  = 2'd1;
  localparam logic [MODE_W-1:0] TM_BOTH  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CSTEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WSTEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TMODE    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LWGT_W-1:0]  load_weight;
    logic [COUNT_W-1:0] load_asked;
    logic [COUNT_W-1:0] load_right;
    logic [DRAW_W-1:0]  draw_value;
    logic               coin_bit;
  } awp_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]    current_index;
    logic                direction;
    logic [OWGT_W-1:0]   weight_out;
    logic [COUNT_W-1:0]  asked_out;
    logic [COUNT_W-1:0]  right_out;
    logic [TOTAL_W-1:0]  weight_total;
    logic [STATUS_W-1:0] status;
  } awp_out_t;

  typedef struct packed {
    logic                latch;
    logic                load_wr;
    logic                scan_clr;
    logic                scan_rd;
    logic                scan_step;
    logic                pick_uniform;
    logic                pick_found;
    logic                ans_rd;
    logic                ans_wr;
    logic                out_rd;
    logic                st_set;
    logic [STATUS_W-1:0] st_code;
  } awp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              empty;
    logic              full;
    logic              adaptive;
    logic              draw_bad;
    logic              hit;
    logic              last;
  } awp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ANS_RD,
    S_ANS_WR,
    S_OUT_RD,
    S_OUT
  } awp_state_t;

endpackage
`default_nettype wire

/* sv/awp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// awp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module awp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/awp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// awp_ctrl
// Sequencer: decodes an accepted word and steps the datapath through it.
// ----------------------------------------------------------------------------
module awp_ctrl
  import awp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          out_valid,
  input  wire awp_sts_t sts,
  output awp_cmd_t      cmd
);

  awp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.st_set = 1'b1;
        cmd.st_code = ST_OK;
        state_nxt = S_OUT_RD;
        priority if (sts.func == FN_LOAD) begin
          if (sts.full) begin
            cmd.st_code = ST_FULL;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end else if (sts.empty) begin
          cmd.st_code = ST_EMPTY;
        end else if (sts.func == FN_PICK) begin
          priority if (sts.draw_bad) begin
            cmd.st_code = ST_RANGE;
          end else if (sts.adaptive) begin
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN_RD;
          end else begin
            cmd.pick_uniform = 1'b1;
          end
        end else begin
          state_nxt = S_ANS_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        priority if (sts.hit) begin
          cmd.pick_found = 1'b1;
          state_nxt = S_OUT_RD;
        end else if (sts.last) begin
          // walked past every entry without reaching the draw
          cmd.st_set = 1'b1;
          cmd.st_code = ST_RANGE;
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_ANS_RD: begin
        cmd.ans_rd = 1'b1;
        state_nxt = S_ANS_WR;
      end
      S_ANS_WR: begin
        cmd.ans_wr = 1'b1;
        state_nxt = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/awp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// awp_dp
// Datapath: entry table, weight sum, prefix-sum walk and answer updates.
// ----------------------------------------------------------------------------
module awp_dp
  import awp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int WEIGHT_MAX  = WEIGHT_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire awp_in_t               in_data,
  input  wire awp_cmd_t              cmd,
  output awp_sts_t                   sts,
  output awp_out_t                   out_data
);

  localparam int IW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int WW   = $clog2(WEIGHT_MAX + 1);
  localparam int SW   = $clog2(MAX_ENTRIES * WEIGHT_MAX + 1);
  localparam int CMPW = (SW > DRAW_W) ? SW : DRAW_W;
  localparam int EW   = ((WW > STEP_W) ? WW : STEP_W) + 1;
  localparam int RW   = WW + 2 * COUNT_W;

  // configuration
  logic               adaptive_r;
  logic [STEP_W-1:0]  cstep_r;
  logic [STEP_W-1:0]  wstep_r;
  logic [MODE_W-1:0]  tmode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adaptive_r <= 1'b1;
      cstep_r    <= STEP_W'(1);
      wstep_r    <= STEP_W'(1);
      tmode_r    <= TM_BOTH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ADAPTIVE: adaptive_r <= cfg_wdata[0];
        REG_CSTEP:    cstep_r    <= cfg_wdata[STEP_W-1:0];
        REG_WSTEP:    wstep_r    <= cfg_wdata[STEP_W-1:0];
        REG_TMODE:    tmode_r    <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  awp_in_t             item_r;
  logic [CW-1:0]       count_r;
  logic [SW-1:0]       sum_r;
  logic [IW-1:0]       index_r;
  logic                dir_r;
  logic [STATUS_W-1:0] st_r;
  logic [IW-1:0]       scan_r;
  logic [SW-1:0]       acc_r;

  // entry table
  logic          wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [RW-1:0] wr_data, rd_data;

  awp_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [WW-1:0]      rd_w;
  logic [COUNT_W-1:0] rd_asked, rd_right;

  assign rd_w     = rd_data[RW-1 -: WW];
  assign rd_asked = rd_data[2*COUNT_W-1 -: COUNT_W];
  assign rd_right = rd_data[COUNT_W-1:0];

  // load weight clamped to 1..WEIGHT_MAX
  logic [WW-1:0] load_w;
  always_comb begin
    priority if (item_r.load_weight == '0) begin
      load_w = WW'(1);
    end else if (32'(item_r.load_weight) > WEIGHT_MAX) begin
      load_w = WW'(WEIGHT_MAX);
    end else begin
      load_w = WW'(item_r.load_weight);
    end
  end

  // answer update of the current entry
  logic [EW-1:0]      w_e, dec_e, inc_e, nw_e;
  logic [WW-1:0]      new_w;
  logic [COUNT_W-1:0] asked_inc, right_inc, new_right;
  logic               is_right;

  assign is_right = (item_r.func == FN_CORRECT);
  assign w_e      = EW'(rd_w);
  assign dec_e    = w_e - EW'(cstep_r);
  assign inc_e    = w_e + EW'(wstep_r);

  always_comb begin
    if (is_right) begin
      nw_e = (w_e > EW'(cstep_r) && dec_e > EW'(1)) ? dec_e : EW'(1);
    end else begin
      nw_e = (32'(inc_e) > WEIGHT_MAX) ? EW'(WEIGHT_MAX) : inc_e;
    end
  end

  assign new_w     = adaptive_r ? WW'(nw_e) : rd_w;
  assign asked_inc = (rd_asked == COUNT_MAX) ? rd_asked : rd_asked + COUNT_W'(1);
  assign right_inc = (rd_right == COUNT_MAX) ? rd_right : rd_right + COUNT_W'(1);
  assign new_right = is_right ? right_inc : rd_right;

  always_comb begin
    wr_en   = cmd.load_wr | cmd.ans_wr;
    wr_addr = cmd.load_wr ? count_r[IW-1:0] : index_r;
    wr_data = cmd.load_wr ? {load_w, item_r.load_asked, item_r.load_right}
                          : {new_w, asked_inc, new_right};
    rd_en   = cmd.scan_rd | cmd.ans_rd | cmd.out_rd;
    rd_addr = cmd.scan_rd ? scan_r : index_r;
  end

  // prefix walk
  logic [SW-1:0]   acc_nxt;
  logic [CW-1:0]   count_m1;
  logic [CMPW-1:0] draw_x, sum_x;

  assign acc_nxt  = acc_r + SW'(rd_w);
  assign count_m1 = count_r - CW'(1);
  assign draw_x   = CMPW'(item_r.draw_value);
  assign sum_x    = CMPW'(sum_r);

  logic pick_dir;
  always_comb begin
    priority if (tmode_r == TM_TRANS) begin
      pick_dir = 1'b0;
    end else if (tmode_r == TM_WORD) begin
      pick_dir = 1'b1;
    end else begin
      pick_dir = item_r.coin_bit;
    end
  end

  always_comb begin
    sts.func     = item_r.func;
    sts.empty    = (count_r == '0);
    sts.full     = (32'(count_r) >= MAX_ENTRIES);
    sts.adaptive = adaptive_r;
    if (adaptive_r) begin
      sts.draw_bad = (draw_x == '0) || (draw_x > sum_x);
    end else begin
      sts.draw_bad = (32'(item_r.draw_value) >= 32'(count_r));
    end
    sts.hit  = (CMPW'(acc_nxt) >= draw_x);
    sts.last = (scan_r == count_m1[IW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      index_r <= '0;
      dir_r   <= 1'b0;
      st_r    <= ST_OK;
    end else begin
      if (cmd.load_wr) begin
        count_r <= count_r + CW'(1);
        sum_r   <= sum_r + SW'(load_w);
      end
      if (cmd.ans_wr && adaptive_r) begin
        sum_r <= sum_r - SW'(rd_w) + SW'(new_w);
      end
      if (cmd.pick_uniform) begin
        index_r <= IW'(item_r.draw_value);
        dir_r   <= pick_dir;
      end
      if (cmd.pick_found) begin
        index_r <= scan_r;
        dir_r   <= pick_dir;
      end
      if (cmd.st_set) begin
        st_r <= cmd.st_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
      acc_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + IW'(1);
      acc_r  <= acc_nxt;
    end
  end

  always_comb begin
    out_data.current_index = IDX_W'(index_r);
    out_data.direction     = dir_r;
    out_data.weight_total  = TOTAL_W'(sum_r);
    out_data.status        = st_r;
    if (count_r == '0) begin
      out_data.weight_out = '0;
      out_data.asked_out  = '0;
      out_data.right_out  = '0;
    end else begin
      out_data.weight_out = OWGT_W'(rd_w);
      out_data.asked_out  = rd_asked;
      out_data.right_out  = rd_right;
    end
  end

endmodule
`default_nettype wire

/* sv/adaptive_weighted_picker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_weighted_picker
// Table of weighted entries with roulette-wheel pick and answer updates.
// ----------------------------------------------------------------------------
// One word at a time: a word is taken when start is high and busy is low, and
// its result appears on out_data for exactly one cycle with out_valid; the
// receiver must take it then. After the accepting edge, a load, an empty-table
// word or a uniform or rejected pick passes through the decode, output-read and
// output states; a correct or wrong answer also reads, modifies and writes the
// entry (answer-read and answer-write states) between decode and output read. An
// adaptive pick walks the prefix sum through the entry table RAM over its single
// read port, a scan-read and a scan-check state per entry, visiting up to the
// entry count of entries. Busy stays high until the strobe cycle ends. The table
// RAM needs no clearing after reset. Configuration writes are taken at any edge
// with cfg_we high and are meant to be issued while busy is low.
module adaptive_weighted_picker
  import awp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int WEIGHT_MAX  = WEIGHT_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  start,
  output logic                       busy,
  input  wire awp_in_t               in_data,
  output logic                       out_valid,
  output awp_out_t                   out_data
);

  awp_cmd_t cmd;
  awp_sts_t sts;

  awp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  awp_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_MAX  (WEIGHT_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* sim/adaptive_weighted_picker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_weighted_picker_tb
// Self-checking bench: drives load, pick and answer words through the
// start/busy port and predicts each result from its own copy of the entry
// table, the weight sum and the registers. Every strobed result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module adaptive_weighted_picker_tb;
  import awp_pkg::*;

  localparam int TABLE_CAP     = 40;    // table size kept during the random part
  localparam int ERR_SHOW      = 30;
  localparam int SETTLE_CYCLES = 2100;  // longer than a walk over a full table
  // spare mode encoding, behaves as both
  localparam logic [MODE_W-1:0] TM_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start     = 1'b0;
  awp_in_t               in_data   = '0;
  logic                  busy;
  logic                  out_valid;
  awp_out_t              out_data;

  awp_in_t  words_to_send[$];
  awp_out_t due_results[$];
  bit       word_taken   = 1'b0;
  int       gap_pct      = 0;
  int       words_queued = 0;
  int       words_taken  = 0;
  int       errors       = 0;
  int       status_seen[4];

  // shadow of the block
  bit                 mdl_adaptive = 1'b1;
  logic [STEP_W-1:0]  mdl_cstep    = 7'd1;
  logic [STEP_W-1:0]  mdl_wstep    = 7'd1;
  logic [MODE_W-1:0]  mdl_tmode    = TM_BOTH;
  logic [OWGT_W-1:0]  tbl_wgt   [MAX_ENTRIES_DEF];
  logic [COUNT_W-1:0] tbl_asked [MAX_ENTRIES_DEF];
  logic [COUNT_W-1:0] tbl_right [MAX_ENTRIES_DEF];
  int                 n_entries = 0;
  int                 wgt_sum   = 0;
  int                 peak_sum  = 0;
  logic [IDX_W-1:0]   cur_idx   = '0;
  logic               cur_dir   = 1'b0;

  adaptive_weighted_picker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one word to the shadow table and returns the result it gives
  function automatic awp_out_t step_picker(input awp_in_t w);
    awp_out_t            r;
    logic [STATUS_W-1:0] st;
    int                  acc;
    int                  lw;
    int                  nw;
    int                  k;
    bit                  hit;
    st = ST_OK;
    if (w.func == FN_LOAD) begin
      if (n_entries >= MAX_ENTRIES_DEF) begin
        st = ST_FULL;
      end else begin
        lw = w.load_weight;
        if (lw < 1) lw = 1;
        if (lw > WEIGHT_MAX_DEF) lw = WEIGHT_MAX_DEF;
        tbl_wgt[n_entries]   = OWGT_W'(lw);
        tbl_asked[n_entries] = w.load_asked;
        tbl_right[n_entries] = w.load_right;
        wgt_sum = wgt_sum + lw;
        n_entries++;
      end
    end else if (n_entries == 0) begin
      st = ST_EMPTY;
    end else if (w.func == FN_PICK) begin
      hit = 1'b0;
      if (mdl_adaptive) begin
        if (w.draw_value >= 1 && w.draw_value <= wgt_sum) begin
          acc = 0;
          // first entry whose prefix sum reaches the draw
          for (k = 0; k < n_entries && !hit; k++) begin
            acc = acc + tbl_wgt[k];
            if (acc >= w.draw_value) begin
              cur_idx = IDX_W'(k);
              hit = 1'b1;
            end
          end
        end
      end else if (w.draw_value < n_entries) begin
        cur_idx = IDX_W'(w.draw_value);
        hit = 1'b1;
      end
      if (hit) begin
        case (mdl_tmode)
          TM_TRANS: cur_dir = 1'b0;
          TM_WORD:  cur_dir = 1'b1;
          default:  cur_dir = w.coin_bit;
        endcase
      end else begin
        st = ST_RANGE;
      end
    end else begin
      k = int'(cur_idx);
      if (mdl_adaptive) begin
        if (w.func == FN_CORRECT) begin
          nw = int'(tbl_wgt[k]) - int'(mdl_cstep);
          if (nw < 1) nw = 1;
        end else begin
          nw = int'(tbl_wgt[k]) + int'(mdl_wstep);
          if (nw > WEIGHT_MAX_DEF) nw = WEIGHT_MAX_DEF;
        end
        wgt_sum = wgt_sum - int'(tbl_wgt[k]) + nw;
        tbl_wgt[k] = OWGT_W'(nw);
      end
      if (tbl_asked[k] != COUNT_MAX) tbl_asked[k] = tbl_asked[k] + 1'b1;
      if (w.func == FN_CORRECT && tbl_right[k] != COUNT_MAX)
        tbl_right[k] = tbl_right[k] + 1'b1;
    end
    if (wgt_sum > peak_sum) peak_sum = wgt_sum;

    r.current_index = cur_idx;
    r.direction     = cur_dir;
    if (n_entries > 0) begin
      r.weight_out = tbl_wgt[cur_idx];
      r.asked_out  = tbl_asked[cur_idx];
      r.right_out  = tbl_right[cur_idx];
    end else begin
      r.weight_out = '0;
      r.asked_out  = '0;
      r.right_out  = '0;
    end
    r.weight_total = TOTAL_W'(wgt_sum);
    r.status       = st;
    return r;
  endfunction

  task automatic compare_field(input string tag, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= ERR_SHOW)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
    end
  endtask

  // monitor: checks strobed results, then records a word taken at this edge
  always @(posedge clk) begin
    awp_out_t want;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= ERR_SHOW)
          $display("%0t: result with none due, expected nothing, got %h", $time, out_data);
      end else begin
        want = due_results.pop_front();
        status_seen[want.status]++;
        compare_field("current_index", int'(want.current_index),
                      int'(out_data.current_index));
        compare_field("direction", int'(want.direction), int'(out_data.direction));
        compare_field("weight_out", int'(want.weight_out), int'(out_data.weight_out));
        compare_field("asked_out", int'(want.asked_out), int'(out_data.asked_out));
        compare_field("right_out", int'(want.right_out), int'(out_data.right_out));
        compare_field("weight_total", int'(want.weight_total),
                      int'(out_data.weight_total));
        compare_field("status", int'(want.status), int'(out_data.status));
      end
    end
    if (rst_n && start && !busy) begin
      due_results.push_back(step_picker(in_data));
      words_taken++;
      word_taken = 1'b1;
    end
  end

  // driver: holds a word until taken, then maybe idles before the next
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_data <= words_to_send.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  function automatic awp_in_t noise_word();
    awp_in_t w;
    w.func        = FUNC_W'($urandom_range(3));
    w.load_weight = LWGT_W'($urandom_range(127));
    w.load_asked  = COUNT_W'($urandom_range(65535));
    w.load_right  = COUNT_W'($urandom_range(65535));
    w.draw_value  = DRAW_W'($urandom_range(131071));
    w.coin_bit    = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic queue_word(input awp_in_t w);
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic send(input logic [FUNC_W-1:0] fn, input int lw, input int la,
                      input int lr, input int draw, input bit coin);
    awp_in_t w;
    w.func        = fn;
    w.load_weight = LWGT_W'(lw);
    w.load_asked  = COUNT_W'(la);
    w.load_right  = COUNT_W'(lr);
    w.draw_value  = DRAW_W'(draw);
    w.coin_bit    = coin;
    queue_word(w);
  endtask

  // returns at a rising edge once every queued word has its result back
  task automatic wait_idle(input int settle);
    @(posedge clk);
    while (words_to_send.size() != 0 || start || due_results.size() != 0 || busy)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ADAPTIVE: mdl_adaptive = val[0];
      REG_CSTEP:    mdl_cstep    = val;
      REG_WSTEP:    mdl_wstep    = val;
      REG_TMODE:    mdl_tmode    = val[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input bit adaptive, input logic [STEP_W-1:0] cstep,
                          input logic [STEP_W-1:0] wstep, input logic [MODE_W-1:0] mode);
    write_reg(REG_ADAPTIVE, CFG_DATA_W'(adaptive));
    write_reg(REG_CSTEP, cstep);
    write_reg(REG_WSTEP, wstep);
    write_reg(REG_TMODE, CFG_DATA_W'(mode));
  endtask

  // one short sequence: noise, a few loads, or a pick followed by answers
  task automatic random_burst();
    awp_in_t w;
    int      roll;
    int      aim;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 3)) begin
        w = noise_word();
        if (w.func == FN_LOAD && n_entries >= TABLE_CAP) w.func = FN_PICK;
        queue_word(w);
      end
    end else if (roll < 22 && n_entries < TABLE_CAP) begin
      repeat ($urandom_range(1, 3)) begin
        w = noise_word();
        w.func = FN_LOAD;
        if ($urandom_range(9) != 0)
          w.load_weight = LWGT_W'($urandom_range(1, WEIGHT_MAX_DEF));
        if ($urandom_range(7) == 0) w.load_asked = COUNT_W'(COUNT_MAX - $urandom_range(2));
        if ($urandom_range(7) == 0) w.load_right = COUNT_W'(COUNT_MAX - $urandom_range(2));
        queue_word(w);
      end
    end else begin
      w = noise_word();
      w.func = FN_PICK;
      aim = $urandom_range(11);
      // aim 0 keeps the wild draw, aim 1 lands just past the valid range
      if (aim == 1)
        w.draw_value = DRAW_W'(mdl_adaptive ? wgt_sum + 1 : n_entries);
      else if (aim > 1)
        w.draw_value = DRAW_W'(mdl_adaptive ? $urandom_range(1, wgt_sum)
                                            : $urandom_range(n_entries - 1));
      queue_word(w);
      repeat ($urandom_range(0, 4)) begin
        w = noise_word();
        w.func = $urandom_range(1) ? FN_CORRECT : FN_WRONG;
        queue_word(w);
      end
    end
    wait_idle(0);
  endtask

  initial begin
    #100_000_000;
    $display("adaptive_weighted_picker_tb: done, errors");
    $finish;
  end

  initial begin
    int      ph;
    int      stop_at;
    int      i;
    int      k;
    int      acc;
    awp_in_t w;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, load clamps, draw edges, step limits, modes
    gap_pct = 23;
    set_regs(1'b1, 7'd1, 7'd1, TM_BOTH);
    send(FN_PICK, 0, 0, 0, 1, 1'b0);
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    send(FN_LOAD, 0, 65535, 65535, 0, 1'b0);
    send(FN_LOAD, 127, 0, 0, 0, 1'b0);
    send(FN_LOAD, 100, 65534, 4660, 0, 1'b0);
    send(FN_LOAD, 1, 32768, 32767, 0, 1'b0);
    send(FN_PICK, 0, 0, 0, 0, 1'b1);
    send(FN_PICK, 0, 0, 0, 203, 1'b1);
    send(FN_PICK, 127, 65535, 65535, 131071, 1'b1);
    send(FN_PICK, 0, 0, 0, 1, 1'b1);
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);   // floor, both counts already saturated
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    send(FN_PICK, 0, 0, 0, 203, 1'b0);    // last entry, sum now 203
    send(FN_PICK, 0, 0, 0, 50, 1'b0);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);     // ceiling
    wait_idle(4);
    set_regs(1'b0, 7'd1, 7'd1, TM_TRANS);
    send(FN_PICK, 0, 0, 0, 0, 1'b1);
    send(FN_PICK, 0, 0, 0, 3, 1'b1);
    send(FN_PICK, 0, 0, 0, 4, 1'b1);
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    wait_idle(4);
    set_regs(1'b1, 7'd100, 7'd100, TM_WORD);
    send(FN_PICK, 0, 0, 0, 102, 1'b0);
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    wait_idle(4);
    set_regs(1'b1, 7'd0, 7'd0, TM_SPARE);
    send(FN_PICK, 0, 0, 0, 1, 1'b1);
    send(FN_PICK, 0, 0, 0, 1, 1'b0);
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    wait_idle(4);

    // random part under six register settings and three gap rates
    for (ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 23 : (ph < 4) ? 83 : 0;
      case (ph)
        0: set_regs(1'b1, 7'd1, 7'd1, TM_BOTH);
        1: set_regs(1'b0, 7'd7, 7'd9, TM_TRANS);
        2: set_regs(1'b1, 7'd100, 7'd100, TM_SPARE);
        3: set_regs(1'b1, 7'd0, 7'd0, TM_WORD);
        4: set_regs(1'b0, 7'd50, 7'd2, TM_BOTH);
        default: set_regs(1'($urandom_range(1)), STEP_W'($urandom_range(100)),
                          STEP_W'($urandom_range(100)), MODE_W'($urandom_range(3)));
      endcase
      stop_at = words_queued + 50;
      while (words_queued < stop_at) random_burst();
      wait_idle(4);
    end

    // raise every entry to the ceiling, then fill the table with heavy entries
    gap_pct = 0;
    set_regs(1'b1, 7'd1, 7'd100, TM_BOTH);
    for (i = 0; i < n_entries; i++) begin
      acc = 0;
      for (k = 0; k <= i; k++) acc = acc + tbl_wgt[k];
      send(FN_PICK, 0, 0, 0, acc, i[0]);
      send(FN_WRONG, 0, 0, 0, 0, 1'b0);
      wait_idle(0);
    end
    stop_at = MAX_ENTRIES_DEF - n_entries;
    repeat (stop_at) begin
      w = noise_word();
      w.func = FN_LOAD;
      w.load_weight = LWGT_W'($urandom_range(WEIGHT_MAX_DEF, 127));
      queue_word(w);
    end
    wait_idle(4);

    // full table: no room, full-length walks, largest sum and index
    send(FN_LOAD, 100, 1, 1, 0, 1'b0);
    send(FN_LOAD, 1, 65535, 0, 131071, 1'b1);
    send(FN_PICK, 0, 0, 0, wgt_sum, 1'b1);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    send(FN_PICK, 0, 0, 0, wgt_sum + 1, 1'b1);
    send(FN_PICK, 0, 0, 0, 1, 1'b0);
    wait_idle(0);
    repeat (8) begin
      w = noise_word();
      w.func = FN_PICK;
      w.draw_value = DRAW_W'($urandom_range(1, wgt_sum));
      queue_word(w);
    end
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);
    wait_idle(4);
    set_regs(1'b0, 7'd100, 7'd100, TM_WORD);
    send(FN_PICK, 0, 0, 0, MAX_ENTRIES_DEF - 1, 1'b0);
    send(FN_CORRECT, 0, 0, 0, 0, 1'b0);
    send(FN_WRONG, 0, 0, 0, 0, 1'b0);
    send(FN_PICK, 0, 0, 0, MAX_ENTRIES_DEF, 1'b0);
    send(FN_PICK, 0, 0, 0, 131071, 1'b1);

    wait_idle(SETTLE_CYCLES);
    if (due_results.size() != 0) begin
      errors += due_results.size();
      $display("%0t: %0d results never arrived", $time, due_results.size());
    end
    $display("summary: %0d words taken, results ok %0d, full %0d, out of range %0d,",
             words_taken, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             " empty %0d", status_seen[ST_EMPTY]);
    $display("summary: table grew to %0d entries, weight sum peaked at %0d",
             n_entries, peak_sum);
    if (errors == 0) begin
      $display("adaptive_weighted_picker_tb: done, clean");
    end else begin
      $display("adaptive_weighted_picker_tb: done, errors");
    end
    $finish;
  end

endmodule
